[design/dpe_pkg.sv]
package dpe_pkg;

    localparam int ACC_W         = 48;   // Q32.16 accumulator
    localparam int BPV_W         = 13;   // beats_per_vector register
    localparam int VCNT_W        = 16;   // vector_count register
    localparam int CFG_DATA_W    = 16;   // widest register
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_VECTOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_COUNT     = 1'd1;

    localparam int DEF_LANES     = 4;
    localparam int DEF_ELEM_BITS = 16;
    localparam int DEF_MAX_BEATS = 4096;

    localparam int QUEUE_DEPTH   = 4;

    // per-beat classification made at the front, consumed at the back
    typedef struct packed {
        logic close;   // beat closes a vector
        logic last;    // closing vector is the final one of a run
    } t_beat_flags;

endpackage

[design/dpe_front.sv]
module dpe_front #(
    parameter int LANES     = dpe_pkg::DEF_LANES,
    parameter int ELEM_BITS = dpe_pkg::DEF_ELEM_BITS,
    parameter int MAX_BEATS = dpe_pkg::DEF_MAX_BEATS,
    localparam int TREE_W   = 2 * ELEM_BITS + $clog2(LANES)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [dpe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dpe_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2*LANES*ELEM_BITS-1:0]      i_data,
    input  logic                              i_full,
    output logic                              o_push,
    output logic signed [TREE_W-1:0]          o_tree,
    output dpe_pkg::t_beat_flags              o_flags
);
    import dpe_pkg::*;

    localparam int BEAT_W = $clog2(MAX_BEATS + 1);
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int LVL    = $clog2(LANES);
    localparam int NP     = 1 << LVL;

    // effective limits, clamped when written
    logic [BEAT_W-1:0]  r_beats;
    logic [VCNT_W-1:0]  r_vcount;
    logic [31:0]        w_bpv;

    logic [BEAT_W-1:0]  r_beat_idx;
    logic [VCNT_W-1:0]  r_vec_idx;
    logic               w_close;
    logic               w_last;
    logic               w_accept;
    logic               w_en;

    logic                        r_va;
    logic                        r_vb;
    logic                        r_vc;
    logic signed [ELEM_BITS-1:0] r_a [LANES];
    logic signed [ELEM_BITS-1:0] r_b [LANES];
    logic signed [PROD_W-1:0]    r_prod [LANES];
    logic signed [TREE_W-1:0]    w_node [LVL+1][NP];
    logic signed [TREE_W-1:0]    r_tree;
    t_beat_flags                 r_fa;
    t_beat_flags                 r_fb;
    t_beat_flags                 r_fc;

    assign w_bpv = 32'(i_cfg_wdata[BPV_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beats  <= BEAT_W'(1);
            r_vcount <= VCNT_W'(1);
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_BEATS_PER_VECTOR: begin
                    if (w_bpv == 32'd0)
                        r_beats <= BEAT_W'(1);
                    else if (w_bpv > 32'(MAX_BEATS))
                        r_beats <= BEAT_W'(MAX_BEATS);
                    else
                        r_beats <= BEAT_W'(w_bpv);
                end
                CFG_VECTOR_COUNT: begin
                    if (i_cfg_wdata[VCNT_W-1:0] == '0)
                        r_vcount <= VCNT_W'(1);
                    else
                        r_vcount <= i_cfg_wdata[VCNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // whole front stalls only when its last stage cannot push
    assign w_en     = !r_vc || !i_full;
    assign o_ready  = w_en;
    assign o_push   = r_vc && !i_full;
    assign w_accept = i_valid && w_en;

    assign w_close = ({1'b0, r_beat_idx} + 1'b1) >= {1'b0, r_beats};
    assign w_last  = w_close && (({1'b0, r_vec_idx} + 1'b1) >= {1'b0, r_vcount});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_idx <= '0;
            r_vec_idx  <= '0;
        end else if (w_accept) begin
            if (w_close) begin
                r_beat_idx <= '0;
                r_vec_idx  <= w_last ? '0 : r_vec_idx + 1'b1;
            end else begin
                r_beat_idx <= r_beat_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (w_en) begin
            r_va <= w_accept;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_a[k]    <= i_data[k*ELEM_BITS +: ELEM_BITS];
                r_b[k]    <= i_data[(LANES+k)*ELEM_BITS +: ELEM_BITS];
                r_prod[k] <= r_a[k] * r_b[k];
            end
            r_fa.close <= w_close;
            r_fa.last  <= w_last;
            r_fb       <= r_fa;
            r_fc       <= r_fb;
            r_tree     <= w_node[LVL][0];
        end
    end

    // binary adder tree over the lane products, zero-padded to a power of two
    always_comb begin
        w_node = '{default: '0};
        for (int i = 0; i < NP; i++) begin
            if (i < LANES)
                w_node[0][i] = TREE_W'(r_prod[i]);
        end
        for (int l = 0; l < LVL; l++) begin
            for (int i = 0; i < (NP >> (l + 1)); i++)
                w_node[l+1][i] = w_node[l][2*i] + w_node[l][2*i+1];
        end
    end

    assign o_tree  = r_tree;
    assign o_flags = r_fc;

endmodule

[design/dpe_queue.sv]
module dpe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dpe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (i_push && !i_pop)
                r_count <= r_count + 1'b1;
            else if (i_pop && !i_push)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

[design/dpe_back.sv]
module dpe_back #(
    parameter int TREE_W = 34
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [TREE_W-1:0]          i_tree,
    input  dpe_pkg::t_beat_flags              i_flags,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dpe_pkg::ACC_W-1:0]         o_sum,
    output logic                              o_sat,
    output logic                              o_last
);
    import dpe_pkg::*;

    localparam int SUM_W = ((TREE_W > ACC_W) ? TREE_W : ACC_W) + 1;

    logic signed [ACC_W-1:0] r_acc;
    logic                    r_sat;
    logic signed [SUM_W-1:0] w_sum;
    logic [SUM_W-ACC_W:0]    w_top;
    logic                    w_ovf;
    logic [ACC_W-1:0]        w_clamp;

    logic                    r_out_valid;
    logic [ACC_W-1:0]        r_out_sum;
    logic                    r_out_sat;
    logic                    r_out_last;

    // a non-closing beat never touches the output register, so it drains freely
    assign o_pop = i_valid && (!i_flags.close || !r_out_valid || i_ready);

    assign w_sum   = SUM_W'(r_acc) + SUM_W'(i_tree);
    assign w_top   = w_sum[SUM_W-1:ACC_W-1];
    assign w_ovf   = !((&w_top) || !(|w_top));
    assign w_clamp = !w_ovf ? w_sum[ACC_W-1:0]
                   : (w_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_flags.close) begin
                r_acc       <= '0;
                r_sat       <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (o_pop) begin
                    r_acc <= w_clamp;
                    r_sat <= r_sat | w_ovf;
                end
                if (i_ready)
                    r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_flags.close) begin
            r_out_sum  <= w_clamp;
            r_out_sat  <= r_sat | w_ovf;
            r_out_last <= i_flags.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_sum   = r_out_sum;
    assign o_sat   = r_out_sat;
    assign o_last  = r_out_last;

endmodule

[design/vector_dot_product_engine_core.sv]
// With the queue empty and the output register free, a vector's result appears on m_axis
//   after its closing beat is accepted and passes the input register, product, adder tree,
//   queue write, then the accumulator/output stage.
// Throughput: 1 beat per cycle while the queue has room, set by the saturating accumulate.
// Results wait in an output register while beats keep flowing through a 4-entry queue.
// Reset (i_rst_n low at a clock edge): counters, accumulator and valids clear,
//   beats_per_vector and vector_count return to 1.
module vector_dot_product_engine_core #(
    parameter int LANES     = dpe_pkg::DEF_LANES,
    parameter int ELEM_BITS = dpe_pkg::DEF_ELEM_BITS,
    parameter int MAX_BEATS = dpe_pkg::DEF_MAX_BEATS,
    localparam int IN_W     = ((2 * LANES * ELEM_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [dpe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dpe_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // a_lane0 .. a_lane(LANES-1), b_lane0 .. b_lane(LANES-1), zero pad
    input  logic [IN_W-1:0]                   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // dot_sum
    output logic [dpe_pkg::ACC_W-1:0]         m_axis_tdata,
    // saturated
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import dpe_pkg::*;

    localparam int TREE_W = 2 * ELEM_BITS + $clog2(LANES);
    localparam int FLG_W  = $bits(t_beat_flags);
    localparam int Q_W    = TREE_W + FLG_W;

    logic                     w_push;
    logic                     w_pop;
    logic                     w_full;
    logic                     w_empty;
    logic signed [TREE_W-1:0] w_tree;
    t_beat_flags              w_flags;
    logic [Q_W-1:0]           w_head;
    logic signed [TREE_W-1:0] w_head_tree;
    t_beat_flags              w_head_flags;

    dpe_front #(
        .LANES     (LANES),
        .ELEM_BITS (ELEM_BITS),
        .MAX_BEATS (MAX_BEATS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata[2*LANES*ELEM_BITS-1:0]),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_tree      (w_tree),
        .o_flags     (w_flags)
    );

    dpe_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_flags, w_tree}),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    assign w_head_tree  = w_head[TREE_W-1:0];
    assign w_head_flags = w_head[Q_W-1:TREE_W];

    dpe_back #(
        .TREE_W (TREE_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .i_tree  (w_head_tree),
        .i_flags (w_head_flags),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_sum   (m_axis_tdata),
        .o_sat   (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue popped while empty");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_full)
        else $error("input stalled with room in the queue");

    a_close_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_head_flags.close) |=> m_axis_tvalid)
        else $error("closing beat did not produce a result");

endmodule
